FILE: rtl/ugct_pkg.sv
package ugct_pkg;

  localparam int MAX_CELLS     = 4096;
  localparam int CELL_BITS     = $clog2(MAX_CELLS);
  localparam int PARTICLE_BITS = 16;
  localparam int COUNT_BITS    = 16;
  localparam int CFG_W         = 24;
  localparam int RES_W         = 13;

  localparam logic [PARTICLE_BITS-1:0] HEAD_EMPTY = {PARTICLE_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0]    COUNT_MAX  = {COUNT_BITS{1'b1}};

  // binning datapath widths
  localparam int DIFF_W = 26;
  localparam int HALF_W = 12;
  localparam int PROD_W = DIFF_W + HALF_W;
  localparam int SUM_W  = PROD_W + HALF_W;
  localparam int IDX_W  = DIFF_W + 1;
  localparam int ROW_W  = IDX_W + RES_W + 2;
  localparam int CELL_W = ROW_W + RES_W + 2;
  localparam int BASE_W = 40;
  localparam int SZ_W   = 2 * RES_W;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_QUERY  = 2'd1,
    KIND_CLEAR  = 2'd2
  } kind_e;

  typedef enum logic [2:0] {
    CFG_MIN_X      = 3'd0,
    CFG_MIN_Y      = 3'd1,
    CFG_MIN_Z      = 3'd2,
    CFG_INV_CELL   = 3'd3,
    CFG_RES_X      = 3'd4,
    CFG_RES_Y      = 3'd5,
    CFG_RES_Z      = 3'd6,
    CFG_CELL_TOTAL = 3'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    F_IDLE, F_MUL, F_BIN, F_ROW, F_CELL, F_PUSH
  } front_state_e;

  typedef enum logic [2:0] {
    B_CLR, B_IDLE, B_CALC, B_RD, B_EMIT
  } back_state_e;

  typedef struct packed {
    logic signed [CFG_W-1:0] min_x;
    logic signed [CFG_W-1:0] min_y;
    logic signed [CFG_W-1:0] min_z;
    logic [CFG_W-1:0]        inv_cell_size;
    logic [RES_W-1:0]        res_x;
    logic [RES_W-1:0]        res_y;
    logic [RES_W-1:0]        res_z;
    logic [RES_W-1:0]        cell_total;
  } cfg_t;

  typedef struct packed {
    kind_e                    kind;
    logic                     hit;
    logic [BASE_W-1:0]        base;
    logic [PARTICLE_BITS-1:0] particle;
    logic [SZ_W-1:0]          sz;
  } cmd_t;

  typedef struct packed {
    logic clearing;
  } back_status_t;

endpackage

FILE: rtl/ugct_front.sv
module ugct_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  ugct_pkg::cfg_t        cfg_i,
  input  ugct_pkg::back_status_t status_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            in_kind_i,
  input  logic [23:0]           in_pos_x_i,
  input  logic [23:0]           in_pos_y_i,
  input  logic [23:0]           in_pos_z_i,
  input  logic [22:0]           in_radius_i,
  input  logic [15:0]           in_particle_i,
  output logic                  push_o,
  output ugct_pkg::cmd_t        cmd_o,
  input  logic                  full_i
);
  import ugct_pkg::*;

  front_state_e state_q, state_d;
  kind_e        kind_q;
  logic [PARTICLE_BITS-1:0] part_q;

  logic signed [DIFF_W-1:0] diff_q [3];
  logic signed [DIFF_W-1:0] diff_d [3];
  logic [PROD_W-1:0]        plo_q [3];
  logic [PROD_W-1:0]        phi_q [3];
  logic                     neg_q [3];
  logic signed [IDX_W-1:0]  idx_q [3];
  logic signed [IDX_W-1:0]  idx_d [3];
  logic signed [ROW_W-1:0]  row_q;
  logic signed [CELL_W-1:0] cell_q;
  logic [SZ_W-1:0]          sz_q;

  logic accept;
  logic [23:0] pos [3];
  logic signed [CFG_W-1:0] mins [3];
  logic [RES_W-1:0] res [3];
  logic signed [IDX_W+RES_W:0]   rowp;
  logic signed [ROW_W+RES_W:0]   cellp;
  logic cell_hit;

  assign accept = in_valid_i && in_ready_o;
  assign pos[0] = in_pos_x_i;
  assign pos[1] = in_pos_y_i;
  assign pos[2] = in_pos_z_i;
  assign mins[0] = cfg_i.min_x;
  assign mins[1] = cfg_i.min_y;
  assign mins[2] = cfg_i.min_z;
  assign res[0] = cfg_i.res_x;
  assign res[1] = cfg_i.res_y;
  assign res[2] = cfg_i.res_z;

  always_comb begin
    logic signed [DIFF_W-1:0] rad;
    rad = (kind_e'(in_kind_i) == KIND_QUERY) ? $signed(DIFF_W'(in_radius_i)) : '0;
    for (int a = 0; a < 3; a++) begin
      diff_d[a] = DIFF_W'($signed(pos[a])) - rad - DIFF_W'(mins[a]);
    end
  end

  // bin from the two partial products, clamp the query corner
  always_comb begin
    logic [SUM_W-1:0] sum;
    logic [DIFF_W-1:0] q;
    logic [RES_W-1:0] r;
    logic [RES_W-1:0] hi;
    for (int a = 0; a < 3; a++) begin
      sum = SUM_W'(plo_q[a]) + (SUM_W'(phi_q[a]) << HALF_W);
      q   = sum[SUM_W-1 -: DIFF_W];
      idx_d[a] = neg_q[a] ? -$signed(IDX_W'(q)) : $signed(IDX_W'(q));
      r  = (res[a] < RES_W'(2)) ? RES_W'(2) : res[a];
      hi = r - RES_W'(2);
      if (kind_q == KIND_QUERY) begin
        if (idx_d[a] < 0) begin
          idx_d[a] = '0;
        end
        if (idx_d[a] >= $signed(IDX_W'(hi))) begin
          idx_d[a] = $signed(IDX_W'(hi));
        end
      end
    end
  end

  assign rowp  = idx_q[2] * $signed({1'b0, cfg_i.res_y});
  assign cellp = row_q * $signed({1'b0, cfg_i.res_x});

  always_ff @(posedge clk_i) begin
    logic [DIFF_W-1:0] mag;
    if (accept) begin
      kind_q <= kind_e'(in_kind_i);
      part_q <= in_particle_i;
      for (int a = 0; a < 3; a++) diff_q[a] <= diff_d[a];
    end
    if (state_q == F_MUL) begin
      for (int a = 0; a < 3; a++) begin
        mag = diff_q[a][DIFF_W-1] ? DIFF_W'(-diff_q[a]) : DIFF_W'(diff_q[a]);
        neg_q[a] <= diff_q[a][DIFF_W-1];
        plo_q[a] <= PROD_W'(mag) * PROD_W'(cfg_i.inv_cell_size[HALF_W-1:0]);
        phi_q[a] <= PROD_W'(mag) * PROD_W'(cfg_i.inv_cell_size[CFG_W-1:HALF_W]);
      end
    end
    if (state_q == F_BIN) begin
      for (int a = 0; a < 3; a++) idx_q[a] <= idx_d[a];
    end
    if (state_q == F_ROW) begin
      row_q <= ROW_W'(rowp) + ROW_W'(idx_q[1]);
      sz_q  <= SZ_W'(SZ_W'(cfg_i.res_x) * SZ_W'(cfg_i.res_y));
    end
    if (state_q == F_CELL) begin
      cell_q <= CELL_W'(cellp) + CELL_W'(idx_q[0]);
    end
  end

  assign cell_hit = !cell_q[CELL_W-1] &&
                    (cell_q < $signed(CELL_W'(cfg_i.cell_total))) &&
                    (cell_q < $signed(CELL_W'(MAX_CELLS)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (accept) begin
          case (kind_e'(in_kind_i))
            KIND_INSERT, KIND_QUERY, KIND_CLEAR: state_d = F_MUL;
            default: state_d = F_IDLE;
          endcase
        end
      end
      F_MUL:  state_d = F_BIN;
      F_BIN:  state_d = F_ROW;
      F_ROW:  state_d = F_CELL;
      F_CELL: state_d = F_PUSH;
      F_PUSH: if (!full_i) state_d = F_IDLE;
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE) && !status_i.clearing;
    push_o     = (state_q == F_PUSH) && !full_i;
    cmd_o.kind     = kind_q;
    cmd_o.hit      = cell_hit;
    cmd_o.base     = BASE_W'(cell_q);
    cmd_o.particle = part_q;
    cmd_o.sz       = sz_q;
  end

endmodule

FILE: rtl/ugct_fifo.sv
module ugct_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  ugct_pkg::cmd_t data_i,
  output logic           full_o,
  input  logic           pop_i,
  output ugct_pkg::cmd_t data_o,
  output logic           empty_o
);
  import ugct_pkg::*;

  cmd_t       slot_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign data_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) wr_ptr_q <= ~wr_ptr_q;
      if (pop_i)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push_i) - 2'(pop_i);
    end
  end

endmodule

FILE: rtl/ugct_back.sv
module ugct_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  ugct_pkg::cfg_t         cfg_i,
  output ugct_pkg::back_status_t status_o,
  input  ugct_pkg::cmd_t         cmd_i,
  input  logic                   empty_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [11:0]            out_cell_res_o,
  output logic [15:0]            out_head_o,
  output logic [15:0]            out_count_o,
  output logic                   out_accepted_o,
  output logic                   out_last_o
);
  import ugct_pkg::*;

  localparam logic [CELL_BITS-1:0] ADDR_LAST = CELL_BITS'(MAX_CELLS - 1);

  logic [PARTICLE_BITS-1:0] head_mem  [MAX_CELLS];
  logic [COUNT_BITS-1:0]    count_mem [MAX_CELLS];

  back_state_e state_q, state_d;
  cmd_t        cmd_q;
  logic [2:0]  k_q;
  logic [BASE_W-1:0] cell_q, cell_d;
  logic        hit_q, hit_d;
  logic [CELL_BITS-1:0] clr_addr_q;
  logic        clr_emit_q;
  logic [PARTICLE_BITS-1:0] rd_head_q;
  logic [COUNT_BITS-1:0]    rd_count_q;
  logic        out_free, emit, mem_we;
  logic [CELL_BITS-1:0]     wr_addr;
  logic [PARTICLE_BITS-1:0] wr_head;
  logic [COUNT_BITS-1:0]    wr_count, new_count;

  assign out_free  = !out_valid_o || out_ready_i;
  assign new_count = (rd_count_q == COUNT_MAX) ? COUNT_MAX : rd_count_q + 1'b1;

  always_comb begin
    cell_d = cmd_q.base;
    hit_d  = cmd_q.hit;
    if (cmd_q.kind == KIND_QUERY) begin
      cell_d = cmd_q.base + BASE_W'(k_q[0])
             + (k_q[1] ? BASE_W'(cfg_i.res_x) : '0)
             + (k_q[2] ? BASE_W'(cmd_q.sz) : '0);
      hit_d  = (cell_d < BASE_W'(cfg_i.cell_total)) && (cell_d < BASE_W'(MAX_CELLS));
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      B_CLR: begin
        if (clr_addr_q == ADDR_LAST) state_d = clr_emit_q ? B_EMIT : B_IDLE;
      end
      B_IDLE: begin
        if (!empty_i) state_d = (cmd_i.kind == KIND_CLEAR) ? B_CLR : B_CALC;
      end
      B_CALC: state_d = B_RD;
      B_RD:   state_d = B_EMIT;
      B_EMIT: begin
        if (out_free) begin
          state_d = (cmd_q.kind == KIND_QUERY && k_q != 3'd7) ? B_CALC : B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    pop_o             = (state_q == B_IDLE) && !empty_i;
    status_o.clearing = (state_q == B_CLR);
    emit              = (state_q == B_EMIT) && out_free;
    mem_we   = 1'b0;
    wr_addr  = clr_addr_q;
    wr_head  = HEAD_EMPTY;
    wr_count = '0;
    case (state_q)
      B_CLR: mem_we = 1'b1;
      B_EMIT: begin
        if (emit && cmd_q.kind == KIND_INSERT && hit_q) begin
          mem_we   = 1'b1;
          wr_addr  = cell_q[CELL_BITS-1:0];
          wr_head  = cmd_q.particle;
          wr_count = new_count;
        end
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      head_mem[wr_addr]  <= wr_head;
      count_mem[wr_addr] <= wr_count;
    end
    if (state_q == B_RD) begin
      rd_head_q  <= head_mem[cell_q[CELL_BITS-1:0]];
      rd_count_q <= count_mem[cell_q[CELL_BITS-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cmd_q <= cmd_i;
    if (state_q == B_CALC) begin
      cell_q <= cell_d;
      hit_q  <= hit_d;
    end
    if (emit) begin
      if (state_q == B_EMIT && cmd_q.kind == KIND_CLEAR) begin
        out_cell_res_o <= '0;
        out_head_o     <= HEAD_EMPTY;
        out_count_o    <= '0;
        out_accepted_o <= 1'b1;
        out_last_o     <= 1'b1;
      end else if (cmd_q.kind == KIND_INSERT) begin
        out_cell_res_o <= hit_q ? cell_q[11:0] : '0;
        out_head_o     <= hit_q ? rd_head_q : HEAD_EMPTY;
        out_count_o    <= hit_q ? new_count : '0;
        out_accepted_o <= hit_q;
        out_last_o     <= 1'b1;
      end else begin
        out_cell_res_o <= cell_q[11:0];
        out_head_o     <= hit_q ? rd_head_q : HEAD_EMPTY;
        out_count_o    <= hit_q ? rd_count_q : '0;
        out_accepted_o <= hit_q;
        out_last_o     <= (k_q == 3'd7);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_CLR;
      clr_addr_q  <= '0;
      clr_emit_q  <= 1'b0;
      k_q         <= '0;
      out_valid_o <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == B_CLR) clr_addr_q <= clr_addr_q + 1'b1;
      if (pop_o) begin
        clr_emit_q <= (cmd_i.kind == KIND_CLEAR);
        k_q        <= '0;
      end else if (emit && cmd_q.kind == KIND_QUERY) begin
        k_q <= k_q + 1'b1;
      end
      if (emit) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/uniform_grid_cell_table.sv
// channel   dir  handshake              payload
// s_*       in   s_tvalid_i/s_tready_o  tdata pos_x,pos_y,pos_z,radius,particle; tuser kind
// m_*       out  m_tvalid_o/m_tready_i  tdata cell_res,head,count,accepted; tlast last
// cfg_*     in   cfg_we_i               cfg_idx_i, cfg_data_i
//
// an item passes the binning front through F_MUL, F_BIN, F_ROW, F_CELL and F_PUSH
// (two partial products per axis, the bin, then the row and cell multiplies), one
// command at a time; the table side picks up a command in B_IDLE and makes each result
// word through B_CALC, B_RD and B_EMIT on the single-port cell memory: one word for an
// insert, eight for a query. clear sweeps the table, one cell per cycle, over all 4096
// cells; after reset the same sweep runs while s_tready_o is low.
// a two-entry command queue lets binning continue while results stall on m_tready_i.
module uniform_grid_cell_table (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  input  logic [111:0] s_tdata_i,  // pos_x, pos_y, pos_z, radius, particle
  input  logic [1:0]   s_tuser_i,  // kind
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  output logic [47:0]  m_tdata_o,  // cell_res, head, count, accepted
  output logic         m_tlast_o
);
  import ugct_pkg::*;

  cfg_t         cfg_q;
  back_status_t status;
  cmd_t         push_cmd, pop_cmd;
  logic         push, pop, full, empty;
  logic [11:0]  cell_res;
  logic [15:0]  head, count;
  logic         accepted;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_x         <= '0;
      cfg_q.min_y         <= '0;
      cfg_q.min_z         <= '0;
      cfg_q.inv_cell_size <= CFG_W'(65536);
      cfg_q.res_x         <= RES_W'(16);
      cfg_q.res_y         <= RES_W'(16);
      cfg_q.res_z         <= RES_W'(16);
      cfg_q.cell_total    <= RES_W'(4096);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_MIN_X:      cfg_q.min_x         <= cfg_data_i;
        CFG_MIN_Y:      cfg_q.min_y         <= cfg_data_i;
        CFG_MIN_Z:      cfg_q.min_z         <= cfg_data_i;
        CFG_INV_CELL:   cfg_q.inv_cell_size <= cfg_data_i;
        CFG_RES_X:      cfg_q.res_x         <= cfg_data_i[RES_W-1:0];
        CFG_RES_Y:      cfg_q.res_y         <= cfg_data_i[RES_W-1:0];
        CFG_RES_Z:      cfg_q.res_z         <= cfg_data_i[RES_W-1:0];
        CFG_CELL_TOTAL: cfg_q.cell_total    <= cfg_data_i[RES_W-1:0];
        default:        cfg_q.min_x         <= cfg_q.min_x;
      endcase
    end
  end

  ugct_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .status_i      (status),
    .in_valid_i    (s_tvalid_i),
    .in_ready_o    (s_tready_o),
    .in_kind_i     (s_tuser_i),
    .in_pos_x_i    (s_tdata_i[23:0]),
    .in_pos_y_i    (s_tdata_i[47:24]),
    .in_pos_z_i    (s_tdata_i[71:48]),
    .in_radius_i   (s_tdata_i[94:72]),
    .in_particle_i (s_tdata_i[110:95]),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .full_i        (full)
  );

  ugct_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .data_o  (pop_cmd),
    .empty_o (empty)
  );

  ugct_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .status_o       (status),
    .cmd_i          (pop_cmd),
    .empty_i        (empty),
    .pop_o          (pop),
    .out_valid_o    (m_tvalid_o),
    .out_ready_i    (m_tready_i),
    .out_cell_res_o (cell_res),
    .out_head_o     (head),
    .out_count_o    (count),
    .out_accepted_o (accepted),
    .out_last_o     (m_tlast_o)
  );

  assign m_tdata_o = {3'b000, accepted, count, head, cell_res};

endmodule

FILE: sim/uniform_grid_cell_table_chk.sv
`timescale 1ns / 1ps

module uniform_grid_cell_table_chk (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [23:0]  cfg_data_i,
  input  logic         s_tvalid_i,
  input  logic         s_tready_o,
  input  logic [111:0] s_tdata_i,
  input  logic [1:0]   s_tuser_i,
  input  logic         m_tvalid_o,
  input  logic         m_tready_i,
  input  logic [47:0]  m_tdata_o,
  input  logic         m_tlast_o,
  output int           fail_cnt_o,
  output int           pending_o,
  output int           words_seen_o,
  output int           queries_seen_o
);
  import ugct_pkg::*;

  typedef struct packed {
    logic [11:0] cidx;
    logic [15:0] head;
    logic [15:0] count;
    logic        acc;
    logic        last;
  } cell_word_t;

  longint      grid_min [3];
  longint      inv_cell;
  longint      res [3];
  longint      cells_used;
  logic [15:0] heads [MAX_CELLS];
  logic [15:0] counts [MAX_CELLS];
  cell_word_t  want_q [$];

  assign pending_o = want_q.size();

  function automatic longint sx24(logic [23:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic longint bin_coord(longint diff);
    longint mag;
    longint q;
    mag = diff < 0 ? -diff : diff;
    q = (mag * inv_cell) >>> 24;
    return diff < 0 ? -q : q;
  endfunction

  function automatic bit in_grid(longint c);
    return c >= 0 && c < cells_used && c < MAX_CELLS;
  endfunction

  task automatic push_word(longint c, logic [15:0] h, logic [15:0] n, bit a, bit l);
    cell_word_t w;
    w.cidx = c[11:0];
    w.head = h;
    w.count = n;
    w.acc = a;
    w.last = l;
    want_q = {want_q, w};
  endtask

  task automatic predict_item(logic [1:0] kind, logic [111:0] d);
    longint p [3];
    longint ix [3];
    longint c, base, rad, r;
    p[0] = sx24(d[23:0]);
    p[1] = sx24(d[47:24]);
    p[2] = sx24(d[71:48]);
    rad = longint'(d[94:72]);
    case (kind)
      KIND_INSERT: begin
        for (int a = 0; a < 3; a++) ix[a] = bin_coord(p[a] - grid_min[a]);
        c = (ix[2] * res[1] + ix[1]) * res[0] + ix[0];
        if (in_grid(c)) begin
          push_word(c, heads[c], (counts[c] == COUNT_MAX) ? counts[c] : counts[c] + 16'd1,
                    1, 1);
          heads[c] = d[110:95];
          if (counts[c] != COUNT_MAX) counts[c]++;
        end else begin
          push_word(0, HEAD_EMPTY, 0, 0, 1);
        end
      end
      KIND_QUERY: begin
        for (int a = 0; a < 3; a++) begin
          r = res[a] < 2 ? 2 : res[a];
          ix[a] = bin_coord(p[a] - rad - grid_min[a]);
          if (ix[a] < 0) ix[a] = 0;
          if (ix[a] >= r - 2) ix[a] = r - 2;
        end
        base = (ix[2] * res[1] + ix[1]) * res[0] + ix[0];
        for (int k = 0; k < 8; k++) begin
          c = base + (k & 1) + ((k & 2) ? res[0] : 0) + ((k & 4) ? res[0] * res[1] : 0);
          if (in_grid(c)) push_word(c, heads[c], counts[c], 1, k == 7);
          else push_word(c, HEAD_EMPTY, 0, 0, k == 7);
        end
      end
      KIND_CLEAR: begin
        for (int i = 0; i < MAX_CELLS; i++) begin
          heads[i] = HEAD_EMPTY;
          counts[i] = 0;
        end
        push_word(0, HEAD_EMPTY, 0, 1, 1);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cell_word_t got, w;
    if (!rst_ni) begin
      grid_min = '{0, 0, 0};
      res = '{16, 16, 16};
      inv_cell = 65536;
      cells_used = 4096;
      for (int i = 0; i < MAX_CELLS; i++) begin
        heads[i] = HEAD_EMPTY;
        counts[i] = 0;
      end
      want_q.delete();
      fail_cnt_o <= 0;
      words_seen_o <= 0;
      queries_seen_o <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CFG_MIN_X:      grid_min[0] = sx24(cfg_data_i);
          CFG_MIN_Y:      grid_min[1] = sx24(cfg_data_i);
          CFG_MIN_Z:      grid_min[2] = sx24(cfg_data_i);
          CFG_INV_CELL:   inv_cell = longint'(cfg_data_i);
          CFG_RES_X:      res[0] = longint'(cfg_data_i[12:0]);
          CFG_RES_Y:      res[1] = longint'(cfg_data_i[12:0]);
          CFG_RES_Z:      res[2] = longint'(cfg_data_i[12:0]);
          CFG_CELL_TOTAL: cells_used = longint'(cfg_data_i[12:0]);
          default: ;
        endcase
      end
      if (m_tvalid_o && m_tready_i) begin
        got = {m_tdata_o[11:0], m_tdata_o[27:12], m_tdata_o[43:28], m_tdata_o[44],
               m_tlast_o};
        words_seen_o <= words_seen_o + 1;
        if (want_q.size() == 0) begin
          if (fail_cnt_o < 10) $display("unexpected word %h", got);
          fail_cnt_o <= fail_cnt_o + 1;
        end else begin
          w = want_q.pop_front();
          if (got !== w) begin
            if (fail_cnt_o < 10)
              $display("mismatch: cell %0d/%0d head %h/%h count %0d/%0d acc %b/%b last %b/%b",
                       w.cidx, got.cidx, w.head, got.head, w.count, got.count,
                       w.acc, got.acc, w.last, got.last);
            fail_cnt_o <= fail_cnt_o + 1;
          end
        end
      end
      // inputs accepted this edge: outputs come later, through the front, queue and table side
      if (s_tvalid_i && s_tready_o) begin
        if (s_tuser_i == KIND_QUERY) queries_seen_o <= queries_seen_o + 1;
        predict_item(s_tuser_i, s_tdata_i);
      end
    end
  end

endmodule

FILE: sim/uniform_grid_cell_table_tb.sv
`timescale 1ns / 1ps

module uniform_grid_cell_table_tb;
  import ugct_pkg::*;

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [2:0]   cfg_idx_i = '0;
  logic [23:0]  cfg_data_i = '0;
  logic         s_tvalid_i = 0;
  logic         s_tready_o;
  logic [111:0] s_tdata_i = '0;
  logic [1:0]   s_tuser_i = '0;
  logic         m_tvalid_o;
  logic         m_tready_i = 0;
  logic [47:0]  m_tdata_o;
  logic         m_tlast_o;
  int           fail_cnt, pending, words_seen, queries_seen;
  int           idle_cycles = 0;
  int           items_sent = 0;

  localparam int IDLE_LIMIT = 20000;

  always begin
    #2 clk_i = 1;
    #2 clk_i = 0;
  end

  uniform_grid_cell_table dut (.*);

  uniform_grid_cell_table_chk chk (
    .*, .fail_cnt_o(fail_cnt), .pending_o(pending), .words_seen_o(words_seen),
    .queries_seen_o(queries_seen)
  );

  // result side: random stall before each word, sometimes none at all
  initial begin
    int gap;
    forever begin
      @(posedge clk_i);
      if (m_tready_i && m_tvalid_o) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
          m_tready_i <= 0;
          repeat (gap) @(posedge clk_i);
          m_tready_i <= 1;
        end
      end else begin
        m_tready_i <= 1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no progress, %0d words still due", pending);
      $display("uniform_grid_cell_table_tb: done, errors");
      $finish;
    end
  end

  task automatic write_reg(cfg_idx_e idx, logic [23:0] val);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic send_item(kind_e k, logic [23:0] x, logic [23:0] y, logic [23:0] z,
                           logic [22:0] rad, logic [15:0] part, bit quick = 0);
    int gap;
    gap = quick ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      s_tvalid_i <= 0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1;
    s_tuser_i <= k;
    s_tdata_i <= {1'b0, part, rad, z, y, x};
    @(posedge clk_i);
    while (!s_tready_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic end_burst();
    s_tvalid_i <= 0;
    @(posedge clk_i);
  endtask

  // cell coordinate c with one cell = 256 in Q16.8, plus a fraction
  function automatic logic [23:0] at_cell(int c);
    return 24'(c * 256 + $urandom_range(0, 255));
  endfunction

  task automatic random_items(int n, int rmax);
    kind_e k;
    int    sel;
    for (int i = 0; i < n; i++) begin
      sel = $urandom_range(0, 99);
      k = sel < 60 ? KIND_INSERT : (sel < 97 ? KIND_QUERY : KIND_CLEAR);
      if ($urandom_range(0, 9) == 0)
        send_item(k, 24'($urandom), 24'($urandom), 24'($urandom), 23'($urandom),
                  16'($urandom), $urandom_range(0, 3) == 0);
      else
        send_item(k, at_cell($urandom_range(0, rmax)), at_cell($urandom_range(0, rmax)),
                  at_cell($urandom_range(0, rmax)), 23'($urandom_range(0, 700)),
                  16'($urandom_range(0, 65535)), $urandom_range(0, 3) == 0);
    end
    end_burst();
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: reset geometry, corners, extremes, empty-code particle
    send_item(KIND_INSERT, 24'd0, 24'd0, 24'd0, 23'd0, 16'd5);
    send_item(KIND_INSERT, 24'd100, 24'd50, 24'd10, 23'd0, 16'hFFFF);
    send_item(KIND_INSERT, at_cell(15), at_cell(15), at_cell(15), 23'd0, 16'h1234);
    send_item(KIND_INSERT, at_cell(20), at_cell(0), at_cell(0), 23'd0, 16'd7);
    send_item(KIND_INSERT, at_cell(0), at_cell(17), at_cell(2), 23'd0, 16'd8);
    send_item(KIND_INSERT, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'd0, 16'hAAAA);
    send_item(KIND_INSERT, 24'h800000, 24'h800000, 24'h800000, 23'd0, 16'h5555);
    send_item(KIND_INSERT, -24'sd1, 24'd0, 24'd0, 23'd0, 16'd9);
    send_item(KIND_QUERY, 24'd0, 24'd0, 24'd0, 23'd0, 16'd0);
    send_item(KIND_QUERY, 24'd300, 24'd300, 24'd300, 23'h7FFFFF, 16'hFFFF);
    send_item(KIND_QUERY, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 23'd0, 16'd0);
    send_item(KIND_QUERY, at_cell(15), at_cell(15), at_cell(15), 23'd100, 16'd0);
    send_item(KIND_QUERY, 24'h800000, 24'h7FFFFF, 24'd0, 23'd300, 16'd0);
    send_item(KIND_CLEAR, 24'd0, 24'd0, 24'd0, 23'd0, 16'd0);
    send_item(KIND_QUERY, 24'd0, 24'd0, 24'd0, 23'd0, 16'd0);
    end_burst();
    drain();

    // count saturation check on one cell would need 65535 inserts; ramp a handful
    random_items(70, 17);
    drain();

    // small odd grid, shifted origin, half-size cells, cell_total below product
    write_reg(CFG_MIN_X, -24'sd512);
    write_reg(CFG_MIN_Y, 24'd256);
    write_reg(CFG_MIN_Z, -24'sd1000);
    write_reg(CFG_INV_CELL, 24'd131072);
    write_reg(CFG_RES_X, 24'd2);
    write_reg(CFG_RES_Y, 24'd3);
    write_reg(CFG_RES_Z, 24'd5);
    write_reg(CFG_CELL_TOTAL, 24'd8);
    random_items(50, 6);
    drain();

    // extremes: min/max bounds, smallest and largest reciprocal, res_x of 4096, res_z of 0
    write_reg(CFG_MIN_X, 24'h800000);
    write_reg(CFG_MIN_Y, 24'h7FFFFF);
    write_reg(CFG_MIN_Z, 24'd0);
    write_reg(CFG_INV_CELL, 24'hFFFFFF);
    write_reg(CFG_RES_X, 24'd4096);
    write_reg(CFG_RES_Y, 24'd1);
    write_reg(CFG_RES_Z, 24'd0);
    write_reg(CFG_CELL_TOTAL, 24'd4096);
    random_items(25, 40);
    drain();
    write_reg(CFG_INV_CELL, 24'd1);
    write_reg(CFG_MIN_Y, 24'd0);
    write_reg(CFG_RES_X, 24'd8);
    write_reg(CFG_RES_Y, 24'd8);
    write_reg(CFG_RES_Z, 24'd8);
    write_reg(CFG_CELL_TOTAL, 24'd512);
    random_items(20, 10);
    drain();
    write_reg(CFG_INV_CELL, 24'd65536);
    write_reg(CFG_MIN_X, 24'd0);
    random_items(35, 9);
    drain();

    $display("sent %0d items (%0d queries), checked %0d result words over five geometries",
             items_sent, queries_seen, words_seen);
    if (fail_cnt == 0) begin
      $display("uniform_grid_cell_table_tb: done, clean");
    end else begin
      $display("%0d mismatches", fail_cnt);
      $display("uniform_grid_cell_table_tb: done, errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/ugct_pkg.sv
rtl/ugct_front.sv
rtl/ugct_fifo.sv
rtl/ugct_back.sv
rtl/uniform_grid_cell_table.sv
sim/uniform_grid_cell_table_chk.sv
sim/uniform_grid_cell_table_tb.sv
